@@ hdl/rswp_pkg.sv @@
`timescale 1ns / 1ps

package rswp_pkg;

    localparam int WINDOW_DEFAULT       = 1024;
    localparam int LATENCY_BITS_DEFAULT = 24;

    localparam int CNT_W     = 32;
    localparam int SUM_W     = 48;
    localparam int BYTES_W   = 32;
    localparam int LAT_OUT_W = 24;
    localparam int OPCODE_W  = 4;
    localparam int EVENTS    = 5;

    localparam int PCT_NUM = 95;
    localparam int PCT_DEN = 100;
    localparam int PCT_NUM_W = 7;
    localparam int PCT_REM_W = 7;

    localparam logic [OPCODE_W-1:0] OP_CLEAR        = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_START        = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_FINISH       = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_BACKEND_ERR  = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_TIMEOUT      = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_RATE_LIMITED = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_HIT          = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_MISS         = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_SNAPSHOT     = 4'd8;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (&v) ? v : v + CNT_W'(1);
        return r;
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                  input logic [BYTES_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {{(SUM_W + 1 - BYTES_W){1'b0}}, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

@@ hdl/rswp_ram.sv @@
`timescale 1ns / 1ps

module rswp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/request_stats_window_percentile.sv @@
`timescale 1ns / 1ps
// result: valid in the cycle after an accepted beat for every opcode but a snapshot of a non-empty window
// snapshot: sets the percentile rank with a reciprocal multiply, then finds it by a radix
//   select that rereads the window RAM once per latency bit
// throughput: one beat per cycle for non-snapshot opcodes while rsp_stall is low, no new beat during a snapshot
// reset: async active low, clears all counters, the window pointer and fill count

module request_stats_window_percentile #(
    parameter int WINDOW       = rswp_pkg::WINDOW_DEFAULT,
    parameter int LATENCY_BITS = rswp_pkg::LATENCY_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  logic [rswp_pkg::OPCODE_W-1:0]   opcode,
    input  logic [rswp_pkg::LAT_OUT_W-1:0]  latency,
    input  logic [rswp_pkg::BYTES_W-1:0]    request_bytes_in,
    input  logic [rswp_pkg::BYTES_W-1:0]    request_bytes_out,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output logic [rswp_pkg::CNT_W-1:0]      total_count,
    output logic [rswp_pkg::CNT_W-1:0]      active_count,
    output logic [rswp_pkg::CNT_W-1:0]      backend_error_count,
    output logic [rswp_pkg::CNT_W-1:0]      timeout_count,
    output logic [rswp_pkg::CNT_W-1:0]      rate_limited_count,
    output logic [rswp_pkg::CNT_W-1:0]      hit_count,
    output logic [rswp_pkg::CNT_W-1:0]      miss_count,
    output logic [rswp_pkg::SUM_W-1:0]      bytes_in_total,
    output logic [rswp_pkg::SUM_W-1:0]      bytes_out_total,
    output logic [rswp_pkg::LAT_OUT_W-1:0]  p95_latency,
    output logic                            p95_valid
);

    localparam int PTR_W   = $clog2(WINDOW);
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int LAT_W   = LATENCY_BITS;
    localparam int PROD_W  = FILL_W + rswp_pkg::PCT_NUM_W;
    localparam int RECIP_K = PROD_W + $clog2(rswp_pkg::PCT_DEN);
    localparam int RECIP_W = PROD_W + 1;
    localparam int CNT_W   = rswp_pkg::CNT_W;
    localparam int SUM_W   = rswp_pkg::SUM_W;
    localparam int OUT_W   = rswp_pkg::LAT_OUT_W;

    localparam logic [RECIP_W-1:0] RECIP_C =
        RECIP_W'(((64'd1 << RECIP_K) + 64'(rswp_pkg::PCT_DEN - 1)) / 64'(rswp_pkg::PCT_DEN));

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SCAN = 4'b0100,
        S_BIT  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  active_reg, active_next;
    logic [CNT_W-1:0]  event_reg [rswp_pkg::EVENTS];
    logic [CNT_W-1:0]  event_next [rswp_pkg::EVENTS];
    logic [SUM_W-1:0]  bin_reg, bin_next;
    logic [SUM_W-1:0]  bout_reg, bout_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    logic [FILL_W-1:0] fill_reg, fill_next;

    logic              rsp_valid_reg, rsp_valid_next;
    logic [LAT_W-1:0]  p95_reg, p95_next;
    logic              p95_valid_reg, p95_valid_next;

    logic [PROD_W-1:0] dividend_reg, dividend_next;

    logic [FILL_W-1:0] rank_reg, rank_next;
    logic [FILL_W-1:0] issue_reg, issue_next;
    logic [FILL_W-1:0] hits_reg, hits_next;
    logic              pend_reg, pend_next;
    logic [LAT_W-1:0]  prefix_reg, prefix_next;
    logic [LAT_W-1:0]  bit_sel_reg, bit_sel_next;
    logic [LAT_W-1:0]  hi_mask_reg, hi_mask_next;

    logic                      accept;
    logic                      slot_free;
    logic                      issuing;
    logic [PROD_W+RECIP_W-1:0] recip_prod;
    logic [LAT_W-1:0]          lat_store;
    logic [LAT_W-1:0]          rd_data;
    logic                      match;
    logic [LAT_W-1:0]          prefix_sel;
    logic                      wr_en;

    assign lat_store   = LAT_W'(latency);
    assign p95_latency = OUT_W'(p95_reg);

    assign slot_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall  = !((state_reg == S_IDLE) && slot_free);
    assign accept     = req_valid && !req_stall;
    assign wr_en      = accept && (opcode == rswp_pkg::OP_FINISH);
    assign issuing    = (state_reg == S_SCAN) && (issue_reg != fill_reg);
    assign recip_prod = (PROD_W + RECIP_W)'(dividend_reg) * (PROD_W + RECIP_W)'(RECIP_C);
    assign match      = (((rd_data ^ prefix_reg) & hi_mask_reg) == '0)
                        && ((rd_data & bit_sel_reg) == '0);

    rswp_ram #(
        .WIDTH (LAT_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (ptr_reg),
        .wr_data (lat_store),
        .rd_en   (issuing),
        .rd_addr (issue_reg[PTR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        active_next    = active_reg;
        for (int i = 0; i < rswp_pkg::EVENTS; i++)
        begin
            event_next[i] = event_reg[i];
        end
        bin_next       = bin_reg;
        bout_next      = bout_reg;
        ptr_next       = ptr_reg;
        fill_next      = fill_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        p95_next       = p95_reg;
        p95_valid_next = p95_valid_reg;
        dividend_next  = dividend_reg;
        rank_next      = rank_reg;
        issue_next     = issue_reg;
        hits_next      = hits_reg;
        pend_next      = 1'b0;
        prefix_next    = prefix_reg;
        bit_sel_next   = bit_sel_reg;
        hi_mask_next   = hi_mask_reg;
        prefix_sel     = prefix_reg | bit_sel_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    rsp_valid_next = 1'b1;
                    p95_next       = '0;
                    p95_valid_next = 1'b0;
                    unique case (opcode)
                        rswp_pkg::OP_CLEAR:
                        begin
                            total_next  = '0;
                            active_next = '0;
                            for (int i = 0; i < rswp_pkg::EVENTS; i++)
                            begin
                                event_next[i] = '0;
                            end
                            bin_next  = '0;
                            bout_next = '0;
                            ptr_next  = '0;
                            fill_next = '0;
                        end
                        rswp_pkg::OP_START:
                        begin
                            total_next  = rswp_pkg::sat_inc(total_reg);
                            active_next = rswp_pkg::sat_inc(active_reg);
                        end
                        rswp_pkg::OP_FINISH:
                        begin
                            if (active_reg != '0)
                            begin
                                active_next = active_reg - CNT_W'(1);
                            end
                            bin_next  = rswp_pkg::sat_add(bin_reg, request_bytes_in);
                            bout_next = rswp_pkg::sat_add(bout_reg, request_bytes_out);
                            ptr_next  = (ptr_reg == PTR_W'(WINDOW - 1)) ? '0
                                                                         : ptr_reg + PTR_W'(1);
                            if (fill_reg != FILL_W'(WINDOW))
                            begin
                                fill_next = fill_reg + FILL_W'(1);
                            end
                        end
                        rswp_pkg::OP_BACKEND_ERR,
                        rswp_pkg::OP_TIMEOUT,
                        rswp_pkg::OP_RATE_LIMITED,
                        rswp_pkg::OP_HIT,
                        rswp_pkg::OP_MISS:
                        begin
                            for (int i = 0; i < rswp_pkg::EVENTS; i++)
                            begin
                                if (opcode == rswp_pkg::OP_BACKEND_ERR + rswp_pkg::OPCODE_W'(i))
                                begin
                                    event_next[i] = rswp_pkg::sat_inc(event_reg[i]);
                                end
                            end
                        end
                        rswp_pkg::OP_SNAPSHOT:
                        begin
                            if (fill_reg != '0)
                            begin
                                rsp_valid_next = 1'b0;
                                dividend_next  = PROD_W'(fill_reg - FILL_W'(1))
                                                 * PROD_W'(rswp_pkg::PCT_NUM);
                                state_next     = S_DIV;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DIV:
            begin
                // percentile index by reciprocal multiply, exact over the dividend range
                rank_next    = recip_prod[RECIP_K +: FILL_W];
                prefix_next  = '0;
                bit_sel_next = {1'b1, {(LAT_W - 1){1'b0}}};
                hi_mask_next = '0;
                issue_next   = '0;
                hits_next    = '0;
                state_next   = S_SCAN;
            end
            S_SCAN:
            begin
                // count window entries under the prefix with the current bit clear
                pend_next = issuing;
                if (issuing)
                begin
                    issue_next = issue_reg + FILL_W'(1);
                end
                if (pend_reg && match)
                begin
                    hits_next = hits_reg + FILL_W'(1);
                end
                if (!issuing && !pend_reg)
                begin
                    state_next = S_BIT;
                end
            end
            S_BIT:
            begin
                if (rank_reg >= hits_reg)
                begin
                    rank_next   = rank_reg - hits_reg;
                    prefix_next = prefix_sel;
                end
                if (bit_sel_reg[0])
                begin
                    p95_next       = (rank_reg >= hits_reg) ? prefix_sel : prefix_reg;
                    p95_valid_next = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    bit_sel_next = bit_sel_reg >> 1;
                    hi_mask_next = {1'b1, hi_mask_reg[LAT_W-1:1]};
                    issue_next   = '0;
                    hits_next    = '0;
                    state_next   = S_SCAN;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            total_reg     <= '0;
            active_reg    <= '0;
            for (int i = 0; i < rswp_pkg::EVENTS; i++)
            begin
                event_reg[i] <= '0;
            end
            bin_reg       <= '0;
            bout_reg      <= '0;
            ptr_reg       <= '0;
            fill_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            p95_valid_reg <= 1'b0;
            issue_reg     <= '0;
            hits_reg      <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            active_reg    <= active_next;
            for (int i = 0; i < rswp_pkg::EVENTS; i++)
            begin
                event_reg[i] <= event_next[i];
            end
            bin_reg       <= bin_next;
            bout_reg      <= bout_next;
            ptr_reg       <= ptr_next;
            fill_reg      <= fill_next;
            rsp_valid_reg <= rsp_valid_next;
            p95_valid_reg <= p95_valid_next;
            issue_reg     <= issue_next;
            hits_reg      <= hits_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p95_reg      <= p95_next;
        dividend_reg <= dividend_next;
        rank_reg     <= rank_next;
        prefix_reg   <= prefix_next;
        bit_sel_reg  <= bit_sel_next;
        hi_mask_reg  <= hi_mask_next;
    end

    assign rsp_valid           = rsp_valid_reg;
    assign total_count         = total_reg;
    assign active_count        = active_reg;
    assign backend_error_count = event_reg[0];
    assign timeout_count       = event_reg[1];
    assign rate_limited_count  = event_reg[2];
    assign hit_count           = event_reg[3];
    assign miss_count          = event_reg[4];
    assign bytes_in_total      = bin_reg;
    assign bytes_out_total     = bout_reg;
    assign p95_valid           = p95_valid_reg;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    localparam int OPCODE_W     = rswp_pkg::OPCODE_W;
    localparam int LAT_OUT_W    = rswp_pkg::LAT_OUT_W;
    localparam int BYTES_W      = rswp_pkg::BYTES_W;
    localparam int CNT_W        = rswp_pkg::CNT_W;
    localparam int SUM_W        = rswp_pkg::SUM_W;
    localparam int EVENTS       = rswp_pkg::EVENTS;
    localparam int WIN_DEPTH    = rswp_pkg::WINDOW_DEFAULT;
    localparam int LAT_BITS     = rswp_pkg::LATENCY_BITS_DEFAULT;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_AFTER   = 400;
    localparam int HOLD_CYCLES  = 300;
    localparam int MAX_PRINTS   = 40;
    localparam logic [OPCODE_W-1:0] OP_LAST = '1;

    typedef struct {
        logic [OPCODE_W-1:0]  op;
        logic [LAT_OUT_W-1:0] lat;
        logic [BYTES_W-1:0]   rx_len;
        logic [BYTES_W-1:0]   tx_len;
    } stat_req_t;

    typedef struct {
        logic [CNT_W-1:0]     total;
        logic [CNT_W-1:0]     active;
        logic [CNT_W-1:0]     evt[EVENTS];
        logic [SUM_W-1:0]     sum_in;
        logic [SUM_W-1:0]     sum_out;
        logic [LAT_OUT_W-1:0] p95;
        logic                 p95_ok;
    } stat_snap_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    logic [OPCODE_W-1:0]  opcode = '0;
    logic [LAT_OUT_W-1:0] latency = '0;
    logic [BYTES_W-1:0]   request_bytes_in = '0;
    logic [BYTES_W-1:0]   request_bytes_out = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    logic [CNT_W-1:0]     total_count;
    logic [CNT_W-1:0]     active_count;
    logic [CNT_W-1:0]     backend_error_count;
    logic [CNT_W-1:0]     timeout_count;
    logic [CNT_W-1:0]     rate_limited_count;
    logic [CNT_W-1:0]     hit_count;
    logic [CNT_W-1:0]     miss_count;
    logic [SUM_W-1:0]     bytes_in_total;
    logic [SUM_W-1:0]     bytes_out_total;
    logic [LAT_OUT_W-1:0] p95_latency;
    logic                 p95_valid;

    // predicted block state
    logic [CNT_W-1:0]     stat_total;
    logic [CNT_W-1:0]     stat_active;
    logic [CNT_W-1:0]     evt_count[EVENTS];
    logic [SUM_W-1:0]     bytes_in_sum;
    logic [SUM_W-1:0]     bytes_out_sum;
    logic [LAT_OUT_W-1:0] lat_window[WIN_DEPTH];
    int                   win_ptr;
    int                   win_fill;

    stat_req_t  pending_reqs[$];
    stat_snap_t expected_stats[$];
    stat_req_t  tx_beat;

    int     errors = 0;
    int     beats_total = 0;
    int     beats_accepted = 0;
    int     results_checked = 0;
    int     tx_idle = 0;
    int     rx_wait = 0;
    bit     tx_burst = 1'b0;
    bit     rx_burst = 1'b0;
    logic   long_hold = 1'b0;
    int     hold_count = 0;
    longint cycle_count = 0;
    longint cycle_limit = 64'h7fff_ffff_ffff_ffff;
    longint gen_budget = 0;
    int     gen_fill = 0;

    request_stats_window_percentile dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [CNT_W-1:0] count_up(logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

    function automatic logic [SUM_W-1:0] add_bytes(logic [SUM_W-1:0] sum,
                                                   logic [BYTES_W-1:0] b);
        logic [SUM_W:0] t;
        t = {1'b0, sum} + {{(SUM_W + 1 - BYTES_W){1'b0}}, b};
        return t[SUM_W] ? {SUM_W{1'b1}} : t[SUM_W-1:0];
    endfunction

    function automatic void clear_stats();
        stat_total = '0;
        stat_active = '0;
        foreach (evt_count[i])
            evt_count[i] = '0;
        bytes_in_sum = '0;
        bytes_out_sum = '0;
        win_ptr = 0;
        win_fill = 0;
    endfunction

    function automatic stat_snap_t apply_request(stat_req_t r);
        stat_snap_t s;
        logic [LAT_OUT_W-1:0] sorted[$];
        int ev;
        s.p95 = '0;
        s.p95_ok = 1'b0;
        ev = int'(r.op) - int'(rswp_pkg::OP_BACKEND_ERR);
        case (r.op)
            rswp_pkg::OP_CLEAR:
                clear_stats();
            rswp_pkg::OP_START:
            begin
                stat_total = count_up(stat_total);
                stat_active = count_up(stat_active);
            end
            rswp_pkg::OP_FINISH:
            begin
                if (stat_active != '0)
                    stat_active = stat_active - CNT_W'(1);
                bytes_in_sum = add_bytes(bytes_in_sum, r.rx_len);
                bytes_out_sum = add_bytes(bytes_out_sum, r.tx_len);
                lat_window[win_ptr] = r.lat;
                win_ptr = (win_ptr + 1) % WIN_DEPTH;
                if (win_fill < WIN_DEPTH)
                    win_fill++;
            end
            rswp_pkg::OP_BACKEND_ERR, rswp_pkg::OP_TIMEOUT, rswp_pkg::OP_RATE_LIMITED,
            rswp_pkg::OP_HIT, rswp_pkg::OP_MISS:
                evt_count[ev] = count_up(evt_count[ev]);
            rswp_pkg::OP_SNAPSHOT:
            begin
                if (win_fill > 0)
                begin
                    for (int i = 0; i < win_fill; i++)
                        sorted.insert(sorted.size(), lat_window[i]);
                    sorted.sort();
                    s.p95 = sorted[(win_fill - 1) * rswp_pkg::PCT_NUM / rswp_pkg::PCT_DEN];
                    s.p95_ok = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        s.total = stat_total;
        s.active = stat_active;
        s.evt = evt_count;
        s.sum_in = bytes_in_sum;
        s.sum_out = bytes_out_sum;
        return s;
    endfunction

    function automatic logic [LAT_OUT_W-1:0] rand_latency();
        case ($urandom_range(0, 3))
            0: return LAT_OUT_W'($urandom());
            1: return LAT_OUT_W'($urandom_range(0, 15));
            2: return LAT_OUT_W'($urandom() >> $urandom_range(8, 31));
            default: return $urandom_range(0, 1) ? {LAT_OUT_W{1'b1}} : {LAT_OUT_W{1'b0}};
        endcase
    endfunction

    function automatic logic [BYTES_W-1:0] rand_bytes();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return BYTES_W'($urandom());
        endcase
    endfunction

    function automatic int draw_wait(bit burst);
        return burst ? 0 : int'($urandom_range(0, 4));
    endfunction

    function automatic void queue_req(logic [OPCODE_W-1:0] op,
                                      logic [LAT_OUT_W-1:0] lat,
                                      logic [BYTES_W-1:0] bin,
                                      logic [BYTES_W-1:0] bout);
        stat_req_t r;
        r.op = op;
        r.lat = lat;
        r.rx_len = bin;
        r.tx_len = bout;
        pending_reqs.insert(pending_reqs.size(), r);
        gen_budget += 12;
        if (op == rswp_pkg::OP_CLEAR)
            gen_fill = 0;
        else if (op == rswp_pkg::OP_FINISH && gen_fill < WIN_DEPTH)
            gen_fill++;
        else if (op == rswp_pkg::OP_SNAPSHOT)
            gen_budget += LAT_BITS * (gen_fill + 3) + 32;
    endfunction

    function automatic void queue_op(logic [OPCODE_W-1:0] op);
        queue_req(op, rand_latency(), rand_bytes(), rand_bytes());
    endfunction

    function automatic logic [OPCODE_W-1:0] pick_op(int finish_pct, int snap_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < snap_pct)
            return rswp_pkg::OP_SNAPSHOT;
        if (r < snap_pct + finish_pct)
            return rswp_pkg::OP_FINISH;
        r = $urandom_range(0, 15);
        if (r < 7)
            return rswp_pkg::OP_START;
        if (r < 14)
            return OPCODE_W'(rswp_pkg::OP_BACKEND_ERR + $urandom_range(0, EVENTS - 1));
        return OPCODE_W'($urandom_range(rswp_pkg::OP_SNAPSHOT + 1, OP_LAST));
    endfunction

    task automatic report_error(string msg);
        if (errors < MAX_PRINTS)
            $display("mismatch at cycle %0d: %s", cycle_count, msg);
        errors++;
    endtask

    task automatic compare_field(string name, logic [SUM_W-1:0] got, logic [SUM_W-1:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s got %0h expected %0h",
                                   results_checked, name, got, want));
    endtask

    task automatic check_result();
        stat_snap_t want;
        if (expected_stats.size() == 0)
        begin
            report_error("result beat with no request outstanding");
            return;
        end
        want = expected_stats[0];
        expected_stats.delete(0);
        compare_field("total_count", SUM_W'(total_count), SUM_W'(want.total));
        compare_field("active_count", SUM_W'(active_count), SUM_W'(want.active));
        compare_field("backend_error_count", SUM_W'(backend_error_count), SUM_W'(want.evt[0]));
        compare_field("timeout_count", SUM_W'(timeout_count), SUM_W'(want.evt[1]));
        compare_field("rate_limited_count", SUM_W'(rate_limited_count), SUM_W'(want.evt[2]));
        compare_field("hit_count", SUM_W'(hit_count), SUM_W'(want.evt[3]));
        compare_field("miss_count", SUM_W'(miss_count), SUM_W'(want.evt[4]));
        compare_field("bytes_in_total", bytes_in_total, want.sum_in);
        compare_field("bytes_out_total", bytes_out_total, want.sum_out);
        compare_field("p95_latency", SUM_W'(p95_latency), SUM_W'(want.p95));
        compare_field("p95_valid", SUM_W'(p95_valid), SUM_W'(want.p95_ok));
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            beats_accepted <= 0;
            tx_idle = 0;
            tx_burst = 1'b0;
            clear_stats();
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                expected_stats.insert(expected_stats.size(), apply_request(tx_beat));
                beats_accepted <= beats_accepted + 1;
            end
            if (!req_valid || !req_stall)
            begin
                if (tx_idle > 0)
                begin
                    tx_idle--;
                    req_valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    tx_beat = pending_reqs[0];
                    pending_reqs.delete(0);
                    opcode <= tx_beat.op;
                    latency <= tx_beat.lat;
                    request_bytes_in <= tx_beat.rx_len;
                    request_bytes_out <= tx_beat.tx_len;
                    req_valid <= 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        tx_burst = !tx_burst;
                    tx_idle = draw_wait(tx_burst);
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            results_checked <= 0;
            rx_wait = 0;
            rx_burst = 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                check_result();
                results_checked <= results_checked + 1;
                if ($urandom_range(0, 31) == 0)
                    rx_burst = !rx_burst;
                rx_wait = draw_wait(rx_burst);
            end
            else if (rsp_valid && rx_wait > 0)
            begin
                rx_wait--;
            end
            rsp_stall <= (rx_wait > 0) || long_hold;
        end
    end

    // one long receiver hold-off so the block backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_hold <= 1'b0;
            hold_count <= 0;
        end
        else if (results_checked >= HOLD_AFTER && hold_count < HOLD_CYCLES)
        begin
            long_hold <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
        begin
            long_hold <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > cycle_limit)
        begin
            $display("[request_stats_window_percentile] ERROR");
            $finish;
        end
    end

    initial
    begin
        int n;

        // directed
        queue_op(rswp_pkg::OP_SNAPSHOT);
        queue_req(rswp_pkg::OP_FINISH, '0, '0, '0);
        queue_op(rswp_pkg::OP_SNAPSHOT);
        queue_op(rswp_pkg::OP_START);
        queue_op(rswp_pkg::OP_START);
        queue_req(rswp_pkg::OP_FINISH, '1, '1, '1);
        queue_req(rswp_pkg::OP_FINISH, LAT_OUT_W'(1), '1, '0);
        queue_req(rswp_pkg::OP_FINISH, LAT_OUT_W'(24'h800000), '0, '1);
        queue_op(rswp_pkg::OP_SNAPSHOT);
        queue_op(rswp_pkg::OP_BACKEND_ERR);
        queue_op(rswp_pkg::OP_TIMEOUT);
        queue_op(rswp_pkg::OP_RATE_LIMITED);
        queue_op(rswp_pkg::OP_HIT);
        queue_op(rswp_pkg::OP_MISS);
        queue_op(OPCODE_W'(rswp_pkg::OP_SNAPSHOT + 1));
        queue_op(OP_LAST);
        queue_op(rswp_pkg::OP_SNAPSHOT);
        queue_op(rswp_pkg::OP_CLEAR);
        queue_op(rswp_pkg::OP_SNAPSHOT);
        queue_op(rswp_pkg::OP_START);
        queue_req(rswp_pkg::OP_FINISH, LAT_OUT_W'(5), '1, '1);
        queue_req(rswp_pkg::OP_FINISH, LAT_OUT_W'(5), '1, '1);
        queue_req(rswp_pkg::OP_FINISH, LAT_OUT_W'(3), '0, '0);
        queue_op(rswp_pkg::OP_SNAPSHOT);

        // short sessions with small windows
        for (int s = 0; s < 8; s++)
        begin
            queue_op(rswp_pkg::OP_CLEAR);
            n = $urandom_range(30, 60);
            for (int i = 0; i < n; i++)
                queue_op(pick_op(35, 5));
        end

        // one long session that fills and wraps the window
        queue_op(rswp_pkg::OP_CLEAR);
        for (int i = 0; i < 1250; i++)
            queue_op((i % 150 == 149) ? rswp_pkg::OP_SNAPSHOT : pick_op(92, 0));
        queue_op(rswp_pkg::OP_SNAPSHOT);
        queue_op(rswp_pkg::OP_FINISH);
        queue_op(rswp_pkg::OP_SNAPSHOT);
        queue_op(rswp_pkg::OP_FINISH);
        queue_op(rswp_pkg::OP_SNAPSHOT);

        beats_total = pending_reqs.size();
        cycle_limit = 4 * gen_budget + RESET_CYCLES + HOLD_CYCLES + 20000;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_accepted < beats_total || expected_stats.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("[request_stats_window_percentile] OK");
        else
            $display("[request_stats_window_percentile] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/rswp_pkg.sv
hdl/rswp_ram.sv
hdl/request_stats_window_percentile.sv
verif/tb_top.sv
